### rtl/ghb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ghb_pkg: shared types and codes of the guarded byte heap
// operation, status, register index and size codes, fsm states and the
// check result that travels from the range checker to the top level
// ----------------------------------------------------------------------------
package ghb_pkg;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_ALLOC = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_READ_OOB   = 3'd1,
    ST_WRITE_PROT = 3'd2,
    ST_WRITE_OOB  = 3'd3,
    ST_OVERFLOW   = 3'd4
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  localparam logic [1:0] CFG_PROTECT_BEGIN = 2'd0;
  localparam logic [1:0] CFG_PROTECT_END   = 2'd1;
  localparam logic [1:0] CFG_FREE_PTR_ADDR = 2'd2;

  localparam logic [1:0] SZ_BYTE = 2'd0;
  localparam logic [1:0] SZ_HALF = 2'd1;

  typedef struct packed {
    status_t rd_st;
    status_t wr_st;
  } chk_res_t;

  // index of the last byte touched, for a size code (unused code acts as four bytes)
  function automatic logic [1:0] size_last(logic [1:0] code);
    logic [1:0] r;
    case (code)
      SZ_BYTE: r = 2'd0;
      SZ_HALF: r = 2'd1;
      default: r = 2'd3;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

### rtl/ghb_ifs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ghb_ifs: request and result channels of the guarded byte heap
// valid/ready channels, a transaction moves when both are high
// ----------------------------------------------------------------------------
interface ghb_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [15:0] addr;
  logic [1:0]  access_size;
  logic [31:0] write_data;
  logic [15:0] alloc_length;

  modport source (output valid, op, addr, access_size, write_data, alloc_length,
                  input ready);
  modport sink   (input valid, op, addr, access_size, write_data, alloc_length,
                  output ready);
endinterface

interface ghb_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;
  logic [15:0] alloc_ref;
  logic [2:0]  status;

  modport source (output valid, read_data, alloc_ref, status, input ready);
  modport sink   (input valid, read_data, alloc_ref, status, output ready);
endinterface
`default_nettype wire

### rtl/guarded_byte_heap_with_bump_alloc.sv
`timescale 1ns / 1ps
`default_nettype none
// timing: banks are read at the accepting edge; the execute state then checks,
//   assembles and writes, and registers the result when the out port can take it
// one transaction in flight: no new request is taken until the execute state is done;
//   the next request is taken while a result waits
// reset: control state and the three config registers clear to zero; heap contents
//   are undefined until written, there is no clearing pass
// ----------------------------------------------------------------------------
// guarded_byte_heap_with_bump_alloc: guarded byte heap with bump allocator
// big-endian 1/2/4 byte reads and writes with heap-end and write-protect
// checks, and an allocate that bumps a free pointer kept in the heap
// ----------------------------------------------------------------------------
module guarded_byte_heap_with_bump_alloc #(
  parameter int unsigned HEAP_BYTES = 16384
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  ghb_in_if.sink           in_if,
  ghb_out_if.source        out_if,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata
);

  localparam logic [16:0] HEAP_LIM = 17'(HEAP_BYTES);

  // config registers
  logic [15:0] prot_begin_r;
  logic [15:0] prot_end_r;
  logic [15:0] free_ptr_addr_r;

  // control
  ghb_pkg::state_t state_r;
  ghb_pkg::state_t state_nxt;
  logic            in_fire;
  logic            finish;
  logic            out_valid_r;
  logic            out_valid_nxt;

  // latched transaction
  ghb_pkg::op_t op_r;
  logic [1:0]   size_r;
  logic [15:0]  base_r;
  logic [15:0]  base_nxt;
  logic [31:0]  wdata_r;
  logic [15:0]  len_r;

  // result register
  logic [31:0]          read_data_r;
  logic [15:0]          alloc_ref_r;
  ghb_pkg::status_t     status_r;

  // datapath
  ghb_pkg::chk_res_t    chk;
  logic [1:0]           last;
  logic [1:0]           lane;
  logic [7:0][7:0]      rd_win;
  logic [7:0]           rbyte [4];
  logic [31:0]          read_val;
  logic [15:0]          here;
  logic [16:0]          next_ptr;
  logic [31:0]          wvalue;
  logic [7:0]           vbyte [4];
  logic [7:0][7:0]      wr_win;
  logic [7:0]           wr_be;
  logic                 do_write;
  logic [31:0]          res_read;
  logic [15:0]          res_ref;
  ghb_pkg::status_t     res_st;

  // config port, to be written only while idle; the block itself does not enforce this
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prot_begin_r    <= '0;
      prot_end_r      <= '0;
      free_ptr_addr_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        ghb_pkg::CFG_PROTECT_BEGIN: prot_begin_r    <= cfg_wdata;
        ghb_pkg::CFG_PROTECT_END:   prot_end_r      <= cfg_wdata;
        ghb_pkg::CFG_FREE_PTR_ADDR: free_ptr_addr_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // allocate works on the free pointer, everything else on the request address
  assign base_nxt = (ghb_pkg::op_t'(in_if.op) == ghb_pkg::OP_ALLOC) ? free_ptr_addr_r
                                                                     : in_if.addr;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ghb_pkg::S_IDLE: begin
        if (in_fire) begin
          state_nxt = ghb_pkg::S_EXEC;
        end
      end
      ghb_pkg::S_EXEC: begin
        if (finish) begin
          state_nxt = ghb_pkg::S_IDLE;
        end
      end
      default: state_nxt = ghb_pkg::S_IDLE;
    endcase
  end

  // fsm outputs
  always_comb begin
    in_if.ready   = (state_r == ghb_pkg::S_IDLE);
    in_fire       = in_if.valid && in_if.ready;
    // result can land once the output register is empty or being drained
    finish        = (state_r == ghb_pkg::S_EXEC) && (!out_valid_r || out_if.ready);
    out_valid_nxt = finish ? 1'b1 : (out_if.ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ghb_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r    <= ghb_pkg::op_t'(in_if.op);
      size_r  <= in_if.access_size;
      base_r  <= base_nxt;
      wdata_r <= in_if.write_data;
      len_r   <= in_if.alloc_length;
    end
    if (finish) begin
      read_data_r <= res_read;
      alloc_ref_r <= res_ref;
      status_r    <= res_st;
    end
  end

  // banks are read at accept, data is there for the exec cycle
  ghb_mem #(
    .HEAP_BYTES (HEAP_BYTES)
  ) u_mem (
    .clk     (clk),
    .rd_en   (in_fire),
    .rd_base (base_nxt),
    .rd_win  (rd_win),
    .wr_en   (finish && do_write),
    .wr_base (base_r),
    .wr_win  (wr_win),
    .wr_be   (wr_be)
  );

  ghb_check #(
    .HEAP_BYTES (HEAP_BYTES)
  ) u_check (
    .base       (base_r),
    .last       (last),
    .prot_begin (prot_begin_r),
    .prot_end   (prot_end_r),
    .res        (chk)
  );

  // allocate always moves the two-byte pointer
  assign last = (op_r == ghb_pkg::OP_ALLOC) ? 2'd1 : ghb_pkg::size_last(size_r);
  assign lane = base_r[1:0];

  // bytes of the access, most significant first
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      rbyte[j] = rd_win[3'(lane) + 3'(j)];
    end
    case (last)
      2'd0:    read_val = {24'd0, rbyte[0]};
      2'd1:    read_val = {16'd0, rbyte[0], rbyte[1]};
      default: read_val = {rbyte[0], rbyte[1], rbyte[2], rbyte[3]};
    endcase
  end

  assign here     = {rbyte[0], rbyte[1]};
  assign next_ptr = {1'b0, here} + {1'b0, len_r};
  assign wvalue   = (op_r == ghb_pkg::OP_ALLOC) ? {16'd0, next_ptr[15:0]} : wdata_r;

  // big-endian store: low bytes of the value used for shorter sizes
  always_comb begin
    vbyte[0] = wvalue[31:24];
    vbyte[1] = wvalue[23:16];
    vbyte[2] = wvalue[15:8];
    vbyte[3] = wvalue[7:0];
    case (last)
      2'd0: begin
        vbyte[0] = wvalue[7:0];
      end
      2'd1: begin
        vbyte[0] = wvalue[15:8];
        vbyte[1] = wvalue[7:0];
      end
      default: ;
    endcase
    wr_win = '0;
    wr_be  = '0;
    for (int j = 0; j < 4; j++) begin
      if (2'(j) <= last) begin
        wr_win[3'(lane) + 3'(j)] = vbyte[j];
        wr_be[3'(lane) + 3'(j)]  = 1'b1;
      end
    end
  end

  // result select; a faulting transaction writes nothing
  always_comb begin
    res_read = '0;
    res_ref  = '0;
    res_st   = ghb_pkg::ST_OK;
    do_write = 1'b0;
    case (op_r)
      ghb_pkg::OP_READ: begin
        res_st = chk.rd_st;
        if (chk.rd_st == ghb_pkg::ST_OK) begin
          res_read = read_val;
        end
      end
      ghb_pkg::OP_WRITE: begin
        res_st   = chk.wr_st;
        do_write = (chk.wr_st == ghb_pkg::ST_OK);
      end
      ghb_pkg::OP_ALLOC: begin
        // pointer readable, then fits in heap, then pointer store allowed
        if (chk.rd_st != ghb_pkg::ST_OK) begin
          res_st = chk.rd_st;
        end else if (next_ptr > HEAP_LIM) begin
          res_st = ghb_pkg::ST_OVERFLOW;
        end else if (chk.wr_st != ghb_pkg::ST_OK) begin
          res_st = chk.wr_st;
        end else begin
          do_write = 1'b1;
          res_ref  = here;
        end
      end
      default: ;
    endcase
  end

  assign out_if.valid     = out_valid_r;
  assign out_if.read_data = read_data_r;
  assign out_if.alloc_ref = alloc_ref_r;
  assign out_if.status    = status_r;

endmodule
`default_nettype wire

### rtl/ghb_check.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ghb_check: range checker
// tests up to four bytes from a base address against heap end and
// protected range, first faulting byte decides the write status
// ----------------------------------------------------------------------------
module ghb_check #(
  parameter int unsigned HEAP_BYTES = 16384
) (
  input  logic [15:0]       base,
  input  logic [1:0]        last,
  input  logic [15:0]       prot_begin,
  input  logic [15:0]       prot_end,
  output ghb_pkg::chk_res_t res
);

  localparam logic [16:0] HEAP_LIM = 17'(HEAP_BYTES);

  always_comb begin
    logic [16:0] b;
    logic        used;
    logic        prot;
    logic        oob;
    logic        found;
    res.rd_st = ghb_pkg::ST_OK;
    res.wr_st = ghb_pkg::ST_OK;
    found     = 1'b0;
    for (int i = 0; i < 4; i++) begin
      b    = {1'b0, base} + 17'(i);
      used = (2'(i) <= last);
      prot = (b >= {1'b0, prot_begin}) && (b < {1'b0, prot_end});
      oob  = (b >= HEAP_LIM);
      if (used && oob) begin
        res.rd_st = ghb_pkg::ST_READ_OOB;
      end
      // protection is tested before heap end on each byte
      if (used && !found && (prot || oob)) begin
        found     = 1'b1;
        res.wr_st = prot ? ghb_pkg::ST_WRITE_PROT : ghb_pkg::ST_WRITE_OOB;
      end
    end
  end

endmodule
`default_nettype wire

### rtl/ghb_mem.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ghb_mem: banked byte memory
// two 32-bit banks of even and odd words with byte enables, so any run of
// up to four bytes is one read or one write across both banks
// ----------------------------------------------------------------------------
module ghb_mem #(
  parameter int unsigned HEAP_BYTES = 16384
) (
  input  logic             clk,
  input  logic             rd_en,
  input  logic [15:0]      rd_base,
  output logic [7:0][7:0]  rd_win,
  input  logic             wr_en,
  input  logic [15:0]      wr_base,
  input  logic [7:0][7:0]  wr_win,
  input  logic [7:0]       wr_be
);

  localparam int unsigned ROWS  = (HEAP_BYTES + 7) / 8;
  localparam int unsigned ROW_W = $clog2(ROWS);

  logic [3:0][7:0] bank_e [ROWS];
  logic [3:0][7:0] bank_o [ROWS];

  logic [13:0]      rd_w0;
  logic [ROW_W-1:0] rd_row_e;
  logic [ROW_W-1:0] rd_row_o;
  logic [13:0]      wr_w0;
  logic [ROW_W-1:0] wr_row_e;
  logic [ROW_W-1:0] wr_row_o;
  logic [3:0][7:0]  q_e_r;
  logic [3:0][7:0]  q_o_r;
  logic             par_r;
  logic [3:0][7:0]  wd_e;
  logic [3:0][7:0]  wd_o;
  logic [3:0]       we_e;
  logic [3:0]       we_o;

  // first word w0 sits in bank w0[0]; the following word in the other bank
  assign rd_w0    = rd_base[15:2];
  assign rd_row_o = ROW_W'(rd_w0[13:1]);
  assign rd_row_e = ROW_W'({1'b0, rd_w0[13:1]} + 14'(rd_w0[0]));
  assign wr_w0    = wr_base[15:2];
  assign wr_row_o = ROW_W'(wr_w0[13:1]);
  assign wr_row_e = ROW_W'({1'b0, wr_w0[13:1]} + 14'(wr_w0[0]));

  always_ff @(posedge clk) begin
    if (rd_en) begin
      q_e_r <= bank_e[rd_row_e];
      q_o_r <= bank_o[rd_row_o];
      par_r <= rd_w0[0];
    end
  end

  assign rd_win = par_r ? {q_e_r, q_o_r} : {q_o_r, q_e_r};

  assign wd_e = wr_w0[0] ? wr_win[7:4] : wr_win[3:0];
  assign wd_o = wr_w0[0] ? wr_win[3:0] : wr_win[7:4];
  assign we_e = wr_w0[0] ? wr_be[7:4]  : wr_be[3:0];
  assign we_o = wr_w0[0] ? wr_be[3:0]  : wr_be[7:4];

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      if (wr_en && we_e[i]) begin
        bank_e[wr_row_e][i] <= wd_e[i];
      end
      if (wr_en && we_o[i]) begin
        bank_o[wr_row_o][i] <= wd_o[i];
      end
    end
  end

endmodule
`default_nettype wire

### rtl/ghb_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ghb_checker: port-level checks of the guarded byte heap
// one transaction in flight, results only after work, fault results clean
// ----------------------------------------------------------------------------
module ghb_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] read_data,
  input wire logic [15:0] alloc_ref,
  input wire logic [2:0]  status
);

  // a taken request blocks the next one: ready is low in the cycle after it is taken
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request taken while previous one still executing");

  // a fresh result follows an execute cycle
  a_result_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without an executing transaction");

  // a fault returns no data and no reference
  a_fault_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && status != ghb_pkg::ST_OK) |-> (read_data == 32'd0 && alloc_ref == 16'd0))
    else $error("faulting result carries data");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(read_data) &&
                                   $stable(alloc_ref) && $stable(status)))
    else $error("stalled result changed");

endmodule

bind guarded_byte_heap_with_bump_alloc ghb_checker u_ghb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_if.valid),
  .in_ready  (in_if.ready),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .read_data (out_if.read_data),
  .alloc_ref (out_if.alloc_ref),
  .status    (out_if.status)
);
`default_nettype wire

### sim/guarded_byte_heap_with_bump_alloc_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// guarded_byte_heap_with_bump_alloc_test: self-checking bench for the heap
// drives reads, writes and allocates through the request channel and checks
// every result against a local predictor of the heap. The run walks through
// several protection and free pointer settings. Idle gaps and stalls are drawn
// at random on both channels, and two long receive hold-offs come in set phases.
// ----------------------------------------------------------------------------
module guarded_byte_heap_with_bump_alloc_test;

  localparam int HEAP_BYTES     = 16384;
  localparam int PHASES         = 9;
  localparam int RANDOM_ITEMS   = 133;  // per phase
  localparam int STALL_LIMIT    = 4000; // cycles with no transaction at all
  localparam int SQUEEZE_CYCLES = 400;  // long receive hold-off
  localparam int MAX_REPORTS    = 10;

  // size codes the package does not name
  localparam logic [1:0] SZ_WORD  = 2'd2;
  localparam logic [1:0] SZ_SPARE = 2'd3;

  typedef struct packed {
    ghb_pkg::op_t op;
    logic [15:0]  addr;
    logic [1:0]   size;
    logic [31:0]  wdata;
    logic [15:0]  len;
  } heap_req_t;

  typedef struct packed {
    logic [31:0]      rdata;
    logic [15:0]      alloc_ref;
    ghb_pkg::status_t status;
  } heap_rsp_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_wdata;

  ghb_in_if  in_ch ();
  ghb_out_if out_ch ();

  guarded_byte_heap_with_bump_alloc #(
    .HEAP_BYTES(HEAP_BYTES)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_if    (in_ch),
    .out_if   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // predictor state: heap image and register copies
  logic [7:0] heap_mem [0:HEAP_BYTES-1];
  int         prot_lo;
  int         prot_hi;
  int         free_ptr;

  // stimulus bookkeeping: which bytes hold a defined value
  bit          written_map [0:HEAP_BYTES-1];
  logic [15:0] recent_writes [$];

  heap_req_t requests_waiting [$];
  heap_rsp_t results_due [$];

  // driver and receiver state
  heap_req_t on_offer;
  bit        tx_busy;
  bit        tx_took;
  bit        tx_burst;
  int        tx_gap;
  bit        rx_took;
  bit        rx_burst;
  int        rx_wait;
  bit        rx_hold;
  bit        squeeze_req;

  int        mismatches;
  int        stall_count;
  heap_rsp_t got;
  heap_rsp_t want;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // bytes moved for a size code, the spare code moves four
  function automatic int span_of(logic [1:0] code);
    case (code)
      ghb_pkg::SZ_BYTE: return 1;
      ghb_pkg::SZ_HALF: return 2;
      default: return 4;
    endcase
  endfunction

  // any byte at or past the heap end faults a load
  function automatic ghb_pkg::status_t load_fault(int a, int n);
    if (a + n > HEAP_BYTES) return ghb_pkg::ST_READ_OOB;
    return ghb_pkg::ST_OK;
  endfunction

  // bytes in address order, protection tested before the heap end
  function automatic ghb_pkg::status_t store_fault(int a, int n);
    int i;
    for (i = 0; i < n; i++) begin
      if (a + i >= prot_lo && a + i < prot_hi) return ghb_pkg::ST_WRITE_PROT;
      if (a + i >= HEAP_BYTES) return ghb_pkg::ST_WRITE_OOB;
    end
    return ghb_pkg::ST_OK;
  endfunction

  // expected result of one transaction, updates the heap image on success
  function automatic heap_rsp_t heap_apply(heap_req_t q);
    heap_rsp_t   r;
    int          n;
    int          a;
    int          i;
    logic [15:0] here;
    logic [16:0] bumped;
    r = '0;
    r.status = ghb_pkg::ST_OK;
    n = span_of(q.size);
    a = q.addr;
    case (q.op)
      ghb_pkg::OP_READ: begin
        r.status = load_fault(a, n);
        if (r.status == ghb_pkg::ST_OK) begin
          for (i = 0; i < n; i++) r.rdata = {r.rdata[23:0], heap_mem[a + i]};
        end
      end
      ghb_pkg::OP_WRITE: begin
        r.status = store_fault(a, n);
        if (r.status == ghb_pkg::ST_OK) begin
          // most significant byte lands at the lowest address
          for (i = 0; i < n; i++) heap_mem[a + i] = 8'(q.wdata >> (8 * (n - 1 - i)));
        end
      end
      ghb_pkg::OP_ALLOC: begin
        r.status = load_fault(free_ptr, 2);
        if (r.status == ghb_pkg::ST_OK) begin
          here   = {heap_mem[free_ptr], heap_mem[free_ptr + 1]};
          bumped = {1'b0, here} + {1'b0, q.len};
          if (bumped > HEAP_BYTES) begin
            r.status = ghb_pkg::ST_OVERFLOW;
          end else begin
            r.status = store_fault(free_ptr, 2);
            if (r.status == ghb_pkg::ST_OK) begin
              heap_mem[free_ptr]     = bumped[15:8];
              heap_mem[free_ptr + 1] = bumped[7:0];
              r.alloc_ref            = here;
            end
          end
        end
      end
      default: begin
        // unused op code: all fields zero, nothing changes
      end
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus generation
  // ---------------------------------------------------------------------------

  // a load is safe when it faults or when every byte it touches was written
  function automatic bit can_read(int a, int n);
    int i;
    if (load_fault(a, n) != ghb_pkg::ST_OK) return 1'b1;
    for (i = 0; i < n; i++) begin
      if (!written_map[a + i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic logic [1:0] pick_size();
    int r;
    r = $urandom_range(0, 9);
    if (r < 3) return ghb_pkg::SZ_BYTE;
    if (r < 6) return ghb_pkg::SZ_HALF;
    if (r < 9) return SZ_WORD;
    return SZ_SPARE;
  endfunction

  // mostly a low working window, plus the heap end, the protection edges,
  // the top of the address space and anything at all
  function automatic logic [15:0] pick_addr();
    int r;
    int base;
    r = $urandom_range(0, 99);
    if (r < 50) return 16'($urandom_range(0, 511));
    if (r < 65) return 16'($urandom_range(HEAP_BYTES - 6, HEAP_BYTES + 2));
    if (r < 78) begin
      base = $urandom_range(0, 1) ? prot_lo : prot_hi;
      return 16'(base + int'($urandom_range(0, 6)) - 3);
    end
    if (r < 90) return 16'($urandom);
    return 16'($urandom_range(16'hFFF8, 16'hFFFF));
  endfunction

  // queue one transaction and note which bytes it will define
  task automatic queue_request(heap_req_t q);
    int n;
    int i;
    n = span_of(q.size);
    if (q.op == ghb_pkg::OP_WRITE && store_fault(q.addr, n) == ghb_pkg::ST_OK) begin
      for (i = 0; i < n; i++) written_map[q.addr + i] = 1'b1;
      recent_writes.push_back(q.addr);
      if (recent_writes.size() > 256) void'(recent_writes.pop_front());
    end
    requests_waiting.push_back(q);
  endtask

  task automatic push(ghb_pkg::op_t op, logic [15:0] addr, logic [1:0] size,
                      logic [31:0] wdata, logic [15:0] len);
    heap_req_t q;
    q.op    = op;
    q.addr  = addr;
    q.size  = size;
    q.wdata = wdata;
    q.len   = len;
    queue_request(q);
  endtask

  // short directed opening, runs with protection on 0x100..0x103 and the
  // free pointer at address 0
  task automatic queue_directed();
    push(ghb_pkg::OP_WRITE, 16'h0000, ghb_pkg::SZ_HALF, 32'hA5A5_3E80, 16'h0000); // 16000
    push(ghb_pkg::OP_WRITE, 16'h0002, SZ_WORD,  32'hDEAD_BEEF, 16'hFFFF);
    push(ghb_pkg::OP_READ,  16'h0002, SZ_WORD,  32'hFFFF_FFFF, 16'h0000);
    push(ghb_pkg::OP_READ,  16'h0003, ghb_pkg::SZ_HALF, 32'h0000_0000, 16'h0000);
    push(ghb_pkg::OP_READ,  16'h0005, ghb_pkg::SZ_BYTE, 32'h0000_0000, 16'h0000);
    // spare size code acts as four bytes
    push(ghb_pkg::OP_WRITE, 16'h0006, SZ_SPARE, 32'h0123_4567, 16'h0000);
    push(ghb_pkg::OP_READ,  16'h0006, SZ_SPARE, 32'h0000_0000, 16'h0000);
    // write just below the protected range, then one straddling into it that changes nothing
    push(ghb_pkg::OP_WRITE, 16'h00FC, SZ_WORD,  32'hCAFE_F00D, 16'h0000);
    push(ghb_pkg::OP_WRITE, 16'h00FE, SZ_WORD,  32'h1111_1111, 16'h0000);
    push(ghb_pkg::OP_READ,  16'h00FC, SZ_WORD,  32'h0000_0000, 16'h0000);
    // last protected byte, then the first byte past it
    push(ghb_pkg::OP_WRITE, 16'h0103, ghb_pkg::SZ_BYTE, 32'h0000_005A, 16'h0000);
    push(ghb_pkg::OP_WRITE, 16'h0104, ghb_pkg::SZ_BYTE, 32'hFFFF_FFA5, 16'h0000);
    push(ghb_pkg::OP_READ,  16'h0104, ghb_pkg::SZ_BYTE, 32'h0000_0000, 16'h0000);
    // heap end: last four bytes fit, one further does not
    push(ghb_pkg::OP_WRITE, 16'h3FFC, SZ_WORD,  32'h1122_3344, 16'h0000);
    push(ghb_pkg::OP_WRITE, 16'h3FFD, SZ_WORD,  32'h5566_7788, 16'h0000);
    push(ghb_pkg::OP_READ,  16'h3FFC, SZ_WORD,  32'h0000_0000, 16'h0000);
    push(ghb_pkg::OP_READ,  16'h3FFF, ghb_pkg::SZ_HALF, 32'h0000_0000, 16'h0000);
    push(ghb_pkg::OP_READ,  16'hFFFF, SZ_WORD,  32'h0000_0000, 16'h0000);
    push(ghb_pkg::OP_WRITE, 16'hFFFF, ghb_pkg::SZ_BYTE, 32'h0000_0000, 16'h0000);
    // allocate landing exactly on the heap end, then zero, then one too many
    push(ghb_pkg::OP_ALLOC, 16'hFFFF, SZ_WORD,  32'hFFFF_FFFF, 16'd384);
    push(ghb_pkg::OP_ALLOC, 16'h0000, ghb_pkg::SZ_BYTE, 32'h0000_0000, 16'd0);
    push(ghb_pkg::OP_ALLOC, 16'h0000, ghb_pkg::SZ_BYTE, 32'h0000_0000, 16'd1);
    push(ghb_pkg::OP_WRITE, 16'h0000, ghb_pkg::SZ_HALF, 32'h0000_0000, 16'h0000); // 0
    push(ghb_pkg::OP_ALLOC, 16'h0000, ghb_pkg::SZ_BYTE, 32'h0000_0000, 16'hFFFF);
    push(ghb_pkg::OP_ALLOC, 16'h0000, ghb_pkg::SZ_BYTE, 32'h0000_0000, 16'h0010);
    push(ghb_pkg::OP_NONE,  16'hFFFF, SZ_SPARE, 32'hFFFF_FFFF, 16'hFFFF);
  endtask

  // set the free pointer to a fresh value so that allocates keep succeeding
  task automatic pointer_reset(ref heap_req_t q);
    q.op   = ghb_pkg::OP_WRITE;
    q.addr = 16'(free_ptr);
    q.size = ghb_pkg::SZ_HALF;
    if ($urandom_range(0, 9) < 7) q.wdata[15:0] = 16'($urandom_range(0, 3072));
    else q.wdata[15:0] = 16'($urandom_range(HEAP_BYTES - 64, HEAP_BYTES));
  endtask

  task automatic queue_random();
    heap_req_t q;
    int        r;
    int        tries;
    bit        found;
    q.op    = ghb_pkg::OP_NONE;
    q.addr  = 16'($urandom);
    q.size  = 2'($urandom_range(0, 3));
    q.wdata = $urandom;
    q.len   = 16'($urandom);
    r = $urandom_range(0, 99);
    if (r < 33) begin
      q.op   = ghb_pkg::OP_WRITE;
      q.addr = pick_addr();
      q.size = pick_size();
    end else if (r < 66) begin
      // loads only of defined bytes, fall back to a store
      found = 1'b0;
      tries = 0;
      while (!found && tries < 40) begin
        q.size = pick_size();
        if (recent_writes.size() != 0 && $urandom_range(0, 9) < 6)
          q.addr = 16'(recent_writes[$urandom_range(0, recent_writes.size() - 1)]
                       + $urandom_range(0, 2));
        else
          q.addr = pick_addr();
        found = can_read(q.addr, span_of(q.size));
        tries++;
      end
      q.op = found ? ghb_pkg::OP_READ : ghb_pkg::OP_WRITE;
    end else if (r < 88) begin
      q.op = ghb_pkg::OP_ALLOC;
      r = $urandom_range(0, 99);
      if (r < 65) q.len = 16'($urandom_range(0, 63));
      else if (r < 80) q.len = 16'($urandom_range(0, 4095));
      if (!can_read(free_ptr, 2)) pointer_reset(q);
    end else if (r < 96) begin
      pointer_reset(q);
    end
    queue_request(q);
  endtask

  // protect_begin, protect_end, free_ptr_addr for each phase
  function automatic logic [47:0] phase_setting(int ph);
    case (ph)
      0:       return {16'h0100, 16'h0104, 16'h0000};
      1:       return {16'h0100, 16'h0180, 16'h0040};
      2:       return {16'hFFFF, 16'h0000, 16'h3FFE}; // end below begin, nothing protected
      3:       return {16'h3F00, 16'hFFFF, 16'h0010}; // protection reaches past the heap
      4:       return {16'h0000, 16'hFFFF, 16'h0040}; // everything protected
      5:       return {16'h0000, 16'h0000, 16'hFFFF}; // pointer outside the heap
      6:       return {16'h1234, 16'h1234, 16'h3FFF}; // pointer's second byte outside
      7:       return {16'h0041, 16'h0042, 16'h0040}; // pointer's second byte protected
      default: return {16'h0000, 16'h0000, 16'h0000};
    endcase
  endfunction

  task automatic set_reg(logic [1:0] idx, logic [15:0] v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    case (idx)
      ghb_pkg::CFG_PROTECT_BEGIN: prot_lo  = v;
      ghb_pkg::CFG_PROTECT_END:   prot_hi  = v;
      ghb_pkg::CFG_FREE_PTR_ADDR: free_ptr = v;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // block idle: nothing queued, nothing on offer, nothing outstanding
  task automatic drain();
    while (requests_waiting.size() != 0 || tx_busy || results_due.size() != 0)
      @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // request driver: one transaction on offer at a time, gap drawn per item
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (tx_busy && tx_took) begin
        tx_busy = 1'b0;
        tx_took = 1'b0;
      end
      if (!tx_busy) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_ch.valid <= 1'b0;
        end else if (requests_waiting.size() != 0) begin
          on_offer = requests_waiting.pop_front();
          in_ch.op           <= on_offer.op;
          in_ch.addr         <= on_offer.addr;
          in_ch.access_size  <= on_offer.size;
          in_ch.write_data   <= on_offer.wdata;
          in_ch.alloc_length <= on_offer.len;
          in_ch.valid        <= 1'b1;
          tx_busy = 1'b1;
          // now and then switch between back-to-back and gappy offering
          if ($urandom_range(0, 29) == 0) tx_burst = !tx_burst;
          tx_gap = tx_burst ? 0 : $urandom_range(0, 18);
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // request monitor: predict each accepted transaction
  always @(posedge clk) begin
    heap_req_t seen;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      seen.op    = ghb_pkg::op_t'(in_ch.op);
      seen.addr  = in_ch.addr;
      seen.size  = in_ch.access_size;
      seen.wdata = in_ch.write_data;
      seen.len   = in_ch.alloc_length;
      results_due.push_back(heap_apply(seen));
      tx_took = 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // result receiver: stall drawn per result, long hold-off on request
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (rx_took) begin
        rx_took = 1'b0;
        if ($urandom_range(0, 29) == 0) rx_burst = !rx_burst;
        rx_wait = rx_burst ? 0 : $urandom_range(0, 18);
      end
      if (rx_wait > 0) begin
        rx_wait--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= !rx_hold;
      end
    end
  end

  // hold-off: the sender keeps offering so the block backs up and stalls
  initial begin
    rx_hold = 1'b0;
    forever begin
      @(posedge clk);
      if (squeeze_req) begin
        squeeze_req = 1'b0;
        rx_hold     = 1'b1;
        repeat (SQUEEZE_CYCLES) @(posedge clk);
        rx_hold = 1'b0;
      end
    end
  end

  task automatic flag_mismatch(string what);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("%s: expected rdata=%h ref=%h status=%0d, got rdata=%h ref=%h status=%0d",
               what, want.rdata, want.alloc_ref, want.status,
               got.rdata, got.alloc_ref, got.status);
  endtask

  // result monitor: compare with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      rx_took       = 1'b1;
      got.rdata     = out_ch.read_data;
      got.alloc_ref = out_ch.alloc_ref;
      got.status    = ghb_pkg::status_t'(out_ch.status);
      if (results_due.size() == 0) begin
        want = '0;
        flag_mismatch("result with nothing outstanding");
      end else begin
        want = results_due.pop_front();
        if (got.rdata !== want.rdata || got.alloc_ref !== want.alloc_ref ||
            got.status !== want.status)
          flag_mismatch("result differs");
      end
    end
  end

  // watchdog: give up after a long stretch with no transaction
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_count = 0;
    end else begin
      stall_count++;
      if (stall_count >= STALL_LIMIT) begin
        $display("guarded_byte_heap_with_bump_alloc: mismatch");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // run sequence
  // ---------------------------------------------------------------------------
  initial begin
    int          ph;
    int          k;
    logic [47:0] setting;
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = ghb_pkg::CFG_PROTECT_BEGIN;
    cfg_wdata          = '0;
    in_ch.valid        = 1'b0;
    in_ch.op           = ghb_pkg::OP_READ;
    in_ch.addr         = '0;
    in_ch.access_size  = ghb_pkg::SZ_BYTE;
    in_ch.write_data   = '0;
    in_ch.alloc_length = '0;
    out_ch.ready       = 1'b0;
    prot_lo            = 0;
    prot_hi            = 0;
    free_ptr           = 0;
    tx_busy            = 1'b0;
    tx_took            = 1'b0;
    tx_burst           = 1'b0;
    tx_gap             = 0;
    rx_took            = 1'b0;
    rx_burst           = 1'b0;
    rx_wait            = 0;
    squeeze_req        = 1'b0;
    mismatches         = 0;
    stall_count        = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (ph = 0; ph < PHASES; ph++) begin
      // registers change only with the block idle
      setting = phase_setting(ph);
      set_reg(ghb_pkg::CFG_PROTECT_BEGIN, setting[47:32]);
      set_reg(ghb_pkg::CFG_PROTECT_END,   setting[31:16]);
      set_reg(ghb_pkg::CFG_FREE_PTR_ADDR, setting[15:0]);
      if (ph == 0) queue_directed();
      for (k = 0; k < RANDOM_ITEMS; k++) queue_random();
      if (ph == 1 || ph == 5) squeeze_req = 1'b1;
      drain();
    end

    repeat (8) @(negedge clk);
    if (mismatches == 0 && results_due.size() == 0) begin
      $display("guarded_byte_heap_with_bump_alloc: match");
    end else begin
      $display("guarded_byte_heap_with_bump_alloc: mismatch");
    end
    $finish;
  end

endmodule
